// File: hdl/discount_curve_price_interpolator_assert.svh
// ---------------------------------------------------------------------------
// discount curve price interpolator assertion macros
// shared property forms for the block's concurrent checks
// ---------------------------------------------------------------------------
`ifndef DISCOUNT_CURVE_PRICE_INTERPOLATOR_ASSERT_SVH
`define DISCOUNT_CURVE_PRICE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define DCPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, off during reset
`define DCPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/dcpi_pkg.sv
// ---------------------------------------------------------------------------
// dcpi_pkg
// shared types and constants of the discount curve price interpolator
// ---------------------------------------------------------------------------
`default_nettype none

package dcpi_pkg;

  localparam int MAX_POINTS   = 128;
  localparam int IDX_W        = $clog2(MAX_POINTS);
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);
  localparam int SERIES_TERMS = 15;

  // shared unit widths: 66-bit product or dividend, 33-bit operand
  localparam int UW   = 66;
  localparam int UB   = 33;
  localparam int NB_W = 7;

  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef enum logic [0:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CFG_CURVE_MODE  = 2'd0,
    CFG_FLAT_RATE   = 2'd1,
    CFG_POINT_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [0:0] {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic            start;
    unit_op_t        op;
    logic [NB_W-1:0] nbits;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FMUL_GO,
    S_FMUL_W,
    S_FEXP,
    S_FCHK,
    S_FK_GO,
    S_FK_W,
    S_FTM_GO,
    S_FTM_W,
    S_FTD_GO,
    S_FTD_W,
    S_FSCALE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RD1,
    S_RD1_W,
    S_TSETUP,
    S_TMUL_GO,
    S_TMUL_W,
    S_TDIV_GO,
    S_TDIV_W,
    S_TFIN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: hdl/discount_curve_price_interpolator.sv
// ---------------------------------------------------------------------------
// discount_curve_price_interpolator
// discount price at a maturity from a flat rate or a loaded point table
// ---------------------------------------------------------------------------
// A load word writes one (time, price) point and leaves the block ready. A
// query word with maturity at or below zero goes straight to the done state
// and presents 1.0 once the output register is free. All multiplies and
// divides run through one shared bit-serial multiply/divide unit, one bit per
// cycle. A flat-curve query runs a 31-bit rate multiply and, unless the
// exponent saturates or underflows, six compare-subtract steps of range
// reduction and fourteen series terms of a 30-bit multiply and a 31-bit
// divide each. A table query scans the point store (up to point_count points,
// clamped to 2..128) and then, unless the segment has zero width, runs the
// 33-bit multiply and 66-bit divide of the interpolation. The input is
// stalled for the whole query; the result sits in an output register, so the
// next word can be taken while it waits. The point store has no reset: query
// only points that have been loaded. Configuration writes are taken at any
// time but must only be made while the block is idle.
`default_nettype none

module discount_curve_price_interpolator import dcpi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic        [6:0]  in_point_index,
  input  wire logic signed [31:0] in_point_price,
  input  wire logic        [31:0] in_point_time,
  input  wire logic signed [31:0] in_maturity,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] out_price,
  output logic                    out_saturated,
  output logic                    out_extrapolated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);

  `include "discount_curve_price_interpolator_assert.svh"

  localparam logic signed [41:0] X_MAX   = 42'sd1073741824;
  localparam logic signed [41:0] X_MIN   = -42'sd24696061952;
  localparam logic signed [41:0] YY_OFS  = 42'sd25304878012;
  localparam logic signed [35:0] P_MAX   = 36'sd2147483647;
  localparam logic signed [35:0] P_MIN   = -36'sd2147483648;
  localparam logic        [31:0] PRC_MAX = 32'h7FFF_FFFF;
  localparam logic        [31:0] PRC_MIN = 32'h8000_0000;

  state_t state_r, state_nxt;

  // configuration
  logic        mode_r, mode_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [7:0]  pc_r, pc_nxt;

  // query context
  logic [30:0]      t_r, t_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [31:0]      prev_t_r, prev_t_nxt;
  logic [31:0]      prev_p_r, prev_p_nxt;
  logic [31:0]      ta_r, ta_nxt;
  logic [31:0]      tb_r, tb_nxt;
  logic [31:0]      pa_r, pa_nxt;
  logic [31:0]      pb_r, pb_nxt;
  logic [32:0]      dt_abs_r, dt_abs_nxt;
  logic [32:0]      dp_abs_r, dp_abs_nxt;
  logic [31:0]      den_abs_r, den_abs_nxt;
  logic             neg_r, neg_nxt;

  // flat curve
  logic signed [41:0] x_r, x_nxt;
  logic [35:0]        yy_r, yy_nxt;
  logic [5:0]         k_r, k_nxt;
  logic [29:0]        r_r, r_nxt;
  logic [30:0]        term_r, term_nxt;
  logic [31:0]        sum_r, sum_nxt;
  logic [3:0]         n_term_r, n_term_nxt;

  // result
  logic [31:0] res_price_r, res_price_nxt;
  logic        res_sat_r, res_sat_nxt;
  logic        res_ext_r, res_ext_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_price_r, out_price_nxt;
  logic        out_sat_r, out_sat_nxt;
  logic        out_ext_r, out_ext_nxt;

  // shared unit and point store
  unit_req_t        ureq;
  unit_sts_t        usts;
  logic [UW-1:0]    u_a;
  logic [UB-1:0]    u_b;
  logic [UW-1:0]    u_res;
  logic             mem_wr;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_time;
  logic [31:0]      rd_price;

  logic in_acc;
  logic out_acc;

  // scratch
  logic [32:0]        rate_abs;
  logic [63:0]        p_full;
  logic [32:0]        den;
  logic signed [33:0] dt;
  logic signed [32:0] dp;
  logic signed [41:0] yy_full;
  logic signed [6:0]  kk;
  logic [5:0]         sh;
  logic [35:0]        sv;
  logic signed [35:0] ts;
  logic               hit;
  logic [35:0]        ln2_sh;
  logic [35:0]        yy_sub;
  logic               kbit;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign mem_wr    = in_acc && (in_func == FUNC_LOAD) &&
                     ({1'b0, in_point_index} < 8'(MAX_POINTS));
  assign rd_addr   = (state_r == S_RD1) ? IDX_W'(1) : idx_r[IDX_W-1:0];

  dcpi_mem u_mem (
    .clk        (clk),
    .wr_en      (mem_wr),
    .wr_addr    (IDX_W'(in_point_index)),
    .wr_time    (in_point_time),
    .wr_price   (in_point_price),
    .rd_addr    (rd_addr),
    .rd_time_r  (rd_time),
    .rd_price_r (rd_price)
  );

  dcpi_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .opa   (u_a),
    .opb   (u_b),
    .sts   (usts),
    .res   (u_res)
  );

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    rate_nxt      = rate_r;
    pc_nxt        = pc_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    prev_t_nxt    = prev_t_r;
    prev_p_nxt    = prev_p_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    dt_abs_nxt    = dt_abs_r;
    dp_abs_nxt    = dp_abs_r;
    den_abs_nxt   = den_abs_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    yy_nxt        = yy_r;
    k_nxt         = k_r;
    r_nxt         = r_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    n_term_nxt    = n_term_r;
    res_price_nxt = res_price_r;
    res_sat_nxt   = res_sat_r;
    res_ext_nxt   = res_ext_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_price_nxt = out_price_r;
    out_sat_nxt   = out_sat_r;
    out_ext_nxt   = out_ext_r;
    ureq.start    = 1'b0;
    ureq.op       = UOP_MUL;
    ureq.nbits    = NB_W'(1);
    u_a           = '0;
    u_b           = '0;
    rate_abs      = rate_r[31] ? (33'd0 - {rate_r[31], rate_r}) : {1'b0, rate_r};
    p_full        = '0;
    den           = {1'b0, tb_r} - {1'b0, ta_r};
    dt            = $signed({3'b0, t_r}) - $signed({2'b0, ta_r});
    dp            = $signed({pb_r[31], pb_r}) - $signed({pa_r[31], pa_r});
    yy_full       = x_r + YY_OFS;
    kk            = $signed({1'b0, k_r}) - 7'sd34;
    sh            = '0;
    sv            = '0;
    ts            = '0;
    hit           = ({2'b0, t_r} <= {1'b0, rd_time});
    ln2_sh        = {6'b0, LN2_Q30} << n_term_r;
    kbit          = (yy_r >= ln2_sh);
    yy_sub        = kbit ? (yy_r - ln2_sh) : yy_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CURVE_MODE:  mode_nxt = cfg_data[0];
        CFG_FLAT_RATE:   rate_nxt = cfg_data;
        CFG_POINT_COUNT: pc_nxt   = cfg_data[7:0];
        default:         mode_nxt = mode_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_func == FUNC_QUERY)) begin
          t_nxt       = in_maturity[30:0];
          res_sat_nxt = 1'b0;
          res_ext_nxt = 1'b0;
          idx_nxt     = '0;
          if (pc_r < 8'd2) begin
            n_nxt = CNT_W'(2);
          end else if (int'(pc_r) > MAX_POINTS) begin
            n_nxt = CNT_W'(MAX_POINTS);
          end else begin
            n_nxt = CNT_W'(pc_r);
          end
          if (in_maturity[31] || (in_maturity == 32'sd0)) begin
            res_price_nxt = ONE_Q30;
            state_nxt     = S_DONE;
          end else if (mode_r == 1'b0) begin
            state_nxt = S_FMUL_GO;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end

      // flat curve: |rate| * t
      S_FMUL_GO: begin
        ureq.start = 1'b1;
        ureq.op    = UOP_MUL;
        ureq.nbits = NB_W'(31);
        u_a        = UW'(rate_abs);
        u_b        = UB'(t_r);
        state_nxt  = S_FMUL_W;
      end
      S_FMUL_W: begin
        if (usts.done) begin
          state_nxt = S_FEXP;
        end
      end
      S_FEXP: begin
        // exponent is -rate*t; arithmetic shift floors toward minus infinity
        if (rate_r[31]) begin
          p_full = {2'b0, u_res[61:0]};
        end else begin
          p_full = 64'd0 - {2'b0, u_res[61:0]};
        end
        x_nxt     = $signed(p_full[63:22]);
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (x_r >= X_MAX) begin
          res_price_nxt = PRC_MAX;
          res_sat_nxt   = 1'b1;
          state_nxt     = S_DONE;
        end else if (x_r < X_MIN) begin
          res_price_nxt = '0;
          state_nxt     = S_DONE;
        end else begin
          yy_nxt    = yy_full[35:0];
          state_nxt = S_FK_GO;
        end
      end
      // range reduction: yy = k*ln2 + r, six compare-subtract steps
      S_FK_GO: begin
        k_nxt      = '0;
        n_term_nxt = 4'd5;
        state_nxt  = S_FK_W;
      end
      S_FK_W: begin
        k_nxt  = {k_r[4:0], kbit};
        yy_nxt = yy_sub;
        if (n_term_r == 4'd0) begin
          r_nxt      = yy_sub[29:0];
          term_nxt   = ONE_Q30[30:0];
          sum_nxt    = ONE_Q30;
          n_term_nxt = 4'd1;
          state_nxt  = S_FTM_GO;
        end else begin
          n_term_nxt = n_term_r - 4'd1;
        end
      end
      S_FTM_GO: begin
        ureq.start = 1'b1;
        ureq.op    = UOP_MUL;
        ureq.nbits = NB_W'(30);
        u_a        = UW'(term_r);
        u_b        = UB'(r_r);
        state_nxt  = S_FTM_W;
      end
      S_FTM_W: begin
        if (usts.done) begin
          state_nxt = S_FTD_GO;
        end
      end
      S_FTD_GO: begin
        ureq.start = 1'b1;
        ureq.op    = UOP_DIV;
        ureq.nbits = NB_W'(31);
        u_a        = UW'(u_res[UW-1:30]);
        u_b        = UB'(n_term_r);
        state_nxt  = S_FTD_W;
      end
      S_FTD_W: begin
        if (usts.done) begin
          term_nxt = u_res[30:0];
          sum_nxt  = sum_r + {1'b0, u_res[30:0]};
          if (n_term_r == 4'(SERIES_TERMS - 1)) begin
            state_nxt = S_FSCALE;
          end else begin
            n_term_nxt = n_term_r + 4'd1;
            state_nxt  = S_FTM_GO;
          end
        end
      end
      S_FSCALE: begin
        if (!kk[6]) begin
          sv = {4'b0, sum_r} << kk[5:0];
        end else begin
          // right shift with rounding half up
          sh = 6'(-kk);
          sv = ({4'b0, sum_r} + (36'd1 << (sh - 6'd1))) >> sh;
        end
        if (sv > {4'b0, PRC_MAX}) begin
          res_price_nxt = PRC_MAX;
          res_sat_nxt   = 1'b1;
        end else begin
          res_price_nxt = sv[31:0];
        end
        state_nxt = S_DONE;
      end

      // table curve: scan for first point at or past t
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (hit) begin
          if (idx_r == '0) begin
            ta_nxt      = rd_time;
            pa_nxt      = rd_price;
            res_ext_nxt = ({2'b0, t_r} < {1'b0, rd_time});
            state_nxt   = S_RD1;
          end else begin
            ta_nxt    = prev_t_r;
            pa_nxt    = prev_p_r;
            tb_nxt    = rd_time;
            pb_nxt    = rd_price;
            state_nxt = S_TSETUP;
          end
        end else if (idx_r == n_r - CNT_W'(1)) begin
          // past the last point: extend the last segment
          ta_nxt      = prev_t_r;
          pa_nxt      = prev_p_r;
          tb_nxt      = rd_time;
          pb_nxt      = rd_price;
          res_ext_nxt = 1'b1;
          state_nxt   = S_TSETUP;
        end else begin
          prev_t_nxt = rd_time;
          prev_p_nxt = rd_price;
          idx_nxt    = idx_r + CNT_W'(1);
          state_nxt  = S_SRCH_RD;
        end
      end
      S_RD1: begin
        state_nxt = S_RD1_W;
      end
      S_RD1_W: begin
        tb_nxt    = rd_time;
        pb_nxt    = rd_price;
        state_nxt = S_TSETUP;
      end
      S_TSETUP: begin
        if (den == '0) begin
          res_price_nxt = pa_r;
          state_nxt     = S_DONE;
        end else begin
          dt_abs_nxt  = dt[33] ? 33'(-dt) : dt[32:0];
          dp_abs_nxt  = dp[32] ? 33'(-dp) : 33'(dp);
          den_abs_nxt = den[32] ? 32'(-den) : den[31:0];
          neg_nxt     = dt[33] ^ dp[32] ^ den[32];
          state_nxt   = S_TMUL_GO;
        end
      end
      S_TMUL_GO: begin
        ureq.start = 1'b1;
        ureq.op    = UOP_MUL;
        ureq.nbits = NB_W'(UB);
        u_a        = UW'(dt_abs_r);
        u_b        = dp_abs_r;
        state_nxt  = S_TMUL_W;
      end
      S_TMUL_W: begin
        if (usts.done) begin
          state_nxt = S_TDIV_GO;
        end
      end
      S_TDIV_GO: begin
        ureq.start = 1'b1;
        ureq.op    = UOP_DIV;
        ureq.nbits = NB_W'(UW);
        u_a        = u_res;
        u_b        = UB'(den_abs_r);
        state_nxt  = S_TDIV_W;
      end
      S_TDIV_W: begin
        if (usts.done) begin
          state_nxt = S_TFIN;
        end
      end
      S_TFIN: begin
        if (|u_res[UW-1:34]) begin
          res_sat_nxt   = 1'b1;
          res_price_nxt = neg_r ? PRC_MIN : PRC_MAX;
        end else begin
          if (neg_r) begin
            ts = $signed({{4{pa_r[31]}}, pa_r}) - $signed({2'b0, u_res[33:0]});
          end else begin
            ts = $signed({{4{pa_r[31]}}, pa_r}) + $signed({2'b0, u_res[33:0]});
          end
          if (ts > P_MAX) begin
            res_sat_nxt   = 1'b1;
            res_price_nxt = PRC_MAX;
          end else if (ts < P_MIN) begin
            res_sat_nxt   = 1'b1;
            res_price_nxt = PRC_MIN;
          end else begin
            res_price_nxt = ts[31:0];
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_price_nxt = res_price_r;
          out_sat_nxt   = res_sat_r;
          out_ext_nxt   = res_ext_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      rate_r      <= '0;
      pc_r        <= 8'd2;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      rate_r      <= rate_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    prev_t_r    <= prev_t_nxt;
    prev_p_r    <= prev_p_nxt;
    ta_r        <= ta_nxt;
    tb_r        <= tb_nxt;
    pa_r        <= pa_nxt;
    pb_r        <= pb_nxt;
    dt_abs_r    <= dt_abs_nxt;
    dp_abs_r    <= dp_abs_nxt;
    den_abs_r   <= den_abs_nxt;
    neg_r       <= neg_nxt;
    x_r         <= x_nxt;
    yy_r        <= yy_nxt;
    k_r         <= k_nxt;
    r_r         <= r_nxt;
    term_r      <= term_nxt;
    sum_r       <= sum_nxt;
    n_term_r    <= n_term_nxt;
    res_price_r <= res_price_nxt;
    res_sat_r   <= res_sat_nxt;
    res_ext_r   <= res_ext_nxt;
    out_price_r <= out_price_nxt;
    out_sat_r   <= out_sat_nxt;
    out_ext_r   <= out_ext_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_price        = out_price_r;
  assign out_saturated    = out_sat_r;
  assign out_extrapolated = out_ext_r;

  `DCPI_ASSERT_NOW(a_start_idle, ureq.start, !usts.busy, "unit started while busy")
  `DCPI_ASSERT_NOW(a_done_wait, usts.done,
    (state_r == S_FMUL_W) || (state_r == S_FTM_W) ||
    (state_r == S_FTD_W) || (state_r == S_TMUL_W) || (state_r == S_TDIV_W),
    "unit finished outside a wait state")
  `DCPI_ASSERT_NOW(a_scan_range, state_r == S_SRCH_CMP, idx_r < n_r,
    "table scan past point count")
  `DCPI_ASSERT_NEXT(a_nonpos_fast,
    in_acc && (in_func == FUNC_QUERY) && (in_maturity <= 32'sd0),
    state_r == S_DONE, "nonpositive maturity not answered directly")

endmodule

`default_nettype wire

// File: hdl/dcpi_mem.sv
// ---------------------------------------------------------------------------
// dcpi_mem
// curve point store: one write port, one read port with registered data
// ---------------------------------------------------------------------------
`default_nettype none

module dcpi_mem import dcpi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [31:0]      wr_time,
  input  wire logic [31:0]      wr_price,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [31:0]      rd_time_r,
  output logic      [31:0]      rd_price_r
);

  logic [31:0] time_mem  [MAX_POINTS];
  logic [31:0] price_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr]  <= wr_time;
      price_mem[wr_addr] <= wr_price;
    end
  end

  always_ff @(posedge clk) begin
    rd_time_r  <= time_mem[rd_addr];
    rd_price_r <= price_mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hdl/dcpi_unit.sv
// ---------------------------------------------------------------------------
// dcpi_unit
// shared bit-serial unit: shift-add multiply and restoring divide
// ---------------------------------------------------------------------------
`default_nettype none

module dcpi_unit import dcpi_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire unit_req_t     req,
  input  wire logic [UW-1:0] opa,
  input  wire logic [UB-1:0] opb,
  output unit_sts_t          sts,
  output logic      [UW-1:0] res
);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  unit_op_t        op_r, op_nxt;
  logic [NB_W-1:0] cnt_r, cnt_nxt;
  logic [UW-1:0]   a_r, a_nxt;
  logic [UB-1:0]   b_r, b_nxt;
  logic [UW-1:0]   res_r, res_nxt;
  logic [UB-1:0]   rem_r, rem_nxt;
  logic [UB:0]     rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    res_nxt  = res_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, a_r[UW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = req.nbits;
      b_nxt    = opb;
      res_nxt  = '0;
      rem_nxt  = '0;
      // dividend is left aligned so that only nbits steps are needed
      if (req.op == UOP_DIV) begin
        a_nxt = opa << (NB_W'(UW) - req.nbits);
      end else begin
        a_nxt = opa;
      end
    end else if (busy_r) begin
      unique case (op_r)
        UOP_MUL: begin
          if (b_r[0]) begin
            res_nxt = res_r + a_r;
          end
          a_nxt = {a_r[UW-2:0], 1'b0};
          b_nxt = {1'b0, b_r[UB-1:1]};
        end
        UOP_DIV: begin
          a_nxt = {a_r[UW-2:0], 1'b0};
          if (rem_sh >= {1'b0, b_r}) begin
            rem_nxt = UB'(rem_sh - {1'b0, b_r});
            res_nxt = {res_r[UW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[UB-1:0];
            res_nxt = {res_r[UW-2:0], 1'b0};
          end
        end
        default: begin
          res_nxt = res_r;
        end
      endcase
      cnt_nxt = cnt_r - NB_W'(1);
      if (cnt_r == NB_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = res_r;

endmodule

`default_nettype wire

// File: bench/discount_curve_price_interpolator_test.sv
// ---------------------------------------------------------------------------
// discount_curve_price_interpolator_test
// Drives load and query words into the discount curve block in flat and
// table modes under several register settings. An in-bench price model
// predicts each query answer and a scoreboard compares price and flags.
// ---------------------------------------------------------------------------
`default_nettype none

module discount_curve_price_interpolator_test import dcpi_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 5_000_000;
  localparam longint Q30 = 64'd1073741824;
  localparam longint LN2 = 64'd744261118;

  typedef struct {
    logic [31:0] price;
    logic        sat;
    logic        ext;
  } quote_t;

  class price_board;
    logic [31:0] times [MAX_POINTS];
    logic [31:0] prices [MAX_POINTS];
    logic        mode;
    logic [31:0] rate;
    logic [7:0]  count;
    quote_t      quotes [$];
    int          errors;
    int          matched;

    function void reset_state();
      mode = 1'b0;
      rate = '0;
      count = 8'd2;
      errors = 0;
      matched = 0;
      quotes.delete();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        CFG_CURVE_MODE: mode = data[0];
        CFG_FLAT_RATE: rate = data;
        CFG_POINT_COUNT: count = data[7:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, ref logic sat);
      if (v > 64'sd2147483647) begin
        sat = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint flat_quote(longint t, ref logic sat);
      longint p, x, yy, k, r, sum, term;
      p = -(longint'($signed(rate)) * t);
      x = p >>> 22;  // floor to q30
      if (x >= Q30) begin
        sat = 1'b1;
        return 64'sd2147483647;
      end
      if (x < -23 * Q30) return 0;
      yy = x + 34 * LN2;
      k = yy / LN2;
      r = yy - k * LN2;
      k = k - 34;
      sum = Q30;
      term = Q30;
      for (int n = 1; n < SERIES_TERMS; n++) begin
        term = ((term * r) >>> 30) / n;
        sum = sum + term;
      end
      if (k >= 0) sum = sum << k;
      else sum = (sum + (64'sd1 << (-k - 1))) >>> (-k);
      return clip(sum, sat);
    endfunction

    function longint table_quote(longint t, ref logic sat, ref logic ext);
      int n, i, ia, ib;
      longint ta, tb, pa, pb, dt, dp, den, q;
      logic [127:0] a, b, d, prod, quo;
      logic neg;
      n = count;
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      for (i = 0; i < n; i++)
        if (t <= longint'({32'b0, times[i]})) break;
      if (i == n) begin
        ia = n - 2;
        ib = n - 1;
        ext = 1'b1;
      end else if (i == 0) begin
        ia = 0;
        ib = 1;
        ext = t < longint'({32'b0, times[0]});
      end else begin
        ia = i - 1;
        ib = i;
      end
      ta = {32'b0, times[ia]};
      tb = {32'b0, times[ib]};
      pa = longint'($signed(prices[ia]));
      pb = longint'($signed(prices[ib]));
      den = tb - ta;
      if (den == 0) return pa;
      dt = t - ta;
      dp = pb - pa;
      neg = ((dt < 0) != (dp < 0)) != (den < 0);
      a = {64'b0, (dt < 0) ? -dt : dt};
      b = {64'b0, (dp < 0) ? -dp : dp};
      d = {64'b0, (den < 0) ? -den : den};
      prod = a * b;
      quo = prod / d;
      if (quo > (128'd1 << 40)) begin
        sat = 1'b1;
        return neg ? -64'sd2147483648 : 64'sd2147483647;
      end
      q = longint'(quo[63:0]);
      return clip(neg ? pa - q : pa + q, sat);
    endfunction

    // takes every accepted input word; loads update the table
    function void note_word(func_t f, logic [6:0] idx, logic [31:0] pr, logic [31:0] tm,
                            logic [31:0] mat);
      quote_t e;
      longint t, p;
      if (f == FUNC_LOAD) begin
        prices[idx] = pr;
        times[idx] = tm;
        return;
      end
      e.sat = 1'b0;
      e.ext = 1'b0;
      t = longint'($signed(mat));
      if (t <= 0) p = Q30;
      else if (mode == 1'b0) p = flat_quote(t, e.sat);
      else p = table_quote(t, e.sat, e.ext);
      e.price = p[31:0];
      quotes.push_back(e);
    endfunction

    function void check_word(logic [31:0] price, logic sat, logic ext);
      quote_t e;
      if (quotes.size() == 0) begin
        $display("%0t: unexpected result price %h sat %b ext %b", $time, price, sat, ext);
        errors++;
        return;
      end
      e = quotes.pop_front();
      matched++;
      if (price !== e.price) begin
        $display("%0t: price expected %h actual %h", $time, e.price, price);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
        errors++;
      end
      if (ext !== e.ext) begin
        $display("%0t: extrapolated expected %b actual %b", $time, e.ext, ext);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [6:0] in_point_index = '0;
  logic signed [31:0] in_point_price = '0;
  logic [31:0] in_point_time = '0;
  logic signed [31:0] in_maturity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_price;
  logic out_saturated;
  logic out_extrapolated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  discount_curve_price_interpolator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_point_index(in_point_index), .in_point_price(in_point_price),
    .in_point_time(in_point_time), .in_maturity(in_maturity),
    .out_valid(out_valid), .out_stall(out_stall), .out_price(out_price),
    .out_saturated(out_saturated), .out_extrapolated(out_extrapolated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  price_board board;
  logic [31:0] tb_times [MAX_POINTS];
  int n_words, n_queries, n_cfg, burst_left, stall_left, stall_mode;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("discount_curve_price_interpolator_test: errors");
      $finish;
    end
  end

  // receiver stall pattern: stretches of none, light and heavy stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_price, out_saturated, out_extrapolated);

  task automatic send_word(func_t f, logic [6:0] idx, logic [31:0] pr, logic [31:0] tm,
                           logic [31:0] mat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= f;
    in_point_index <= idx;
    in_point_price <= pr;
    in_point_time <= tm;
    in_maturity <= mat;
    do @(posedge clk); while (in_stall);
    board.note_word(f, idx, pr, tm, mat);
    if (f == FUNC_LOAD) tb_times[idx] = tm;
    else n_queries++;
    n_words++;
  endtask

  task automatic load_point(logic [6:0] idx, logic [31:0] pr, logic [31:0] tm);
    send_word(FUNC_LOAD, idx, pr, tm, $urandom);
  endtask

  task automatic query(logic [31:0] mat);
    send_word(FUNC_QUERY, 7'($urandom), $urandom, $urandom, mat);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.quotes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, data);
    n_cfg++;
  endtask

  function automatic logic [31:0] rand_maturity();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom;
      2: return '0;
      default: return $urandom >> $urandom_range(1, 31);
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  // mostly ascending tables, now and then random times
  task automatic load_table(int n);
    longint t;
    int span;
    logic wild;
    wild = ($urandom_range(0, 5) == 0);
    span = (n > 8) ? (1 << 24) : (1 << $urandom_range(16, 29));
    t = $urandom >> $urandom_range(2, 31);
    for (int i = 0; i < n; i++) begin
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      load_point(i[6:0], $signed($urandom) >>> $urandom_range(0, 4),
                 wild ? $urandom : t[31:0]);
      t = t + $urandom_range(0, span);
    end
  endtask

  initial begin
    int count;
    logic [31:0] off;
    board = new();
    board.reset_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flat curve, zero rate, maturity extremes
    query(32'd0);
    query(32'h8000_0000);
    query(32'd1);
    query(32'h7FFF_FFFF);
    drain();
    write_cfg(CFG_FLAT_RATE, 32'h7FFF_FFFF);
    query(32'h7FFF_FFFF);  // deep underflow to zero
    query(32'h0100_0000);
    drain();
    write_cfg(CFG_FLAT_RATE, 32'h8000_0000);
    query(32'h0100_0000);  // growth above one saturates
    drain();
    write_cfg(CFG_FLAT_RATE, -32'sd67108864);
    query(32'h0100_0000);
    drain();

    // table curve: below, at, between, above, far above
    write_cfg(CFG_CURVE_MODE, 32'd1);
    write_cfg(CFG_POINT_COUNT, 32'd2);
    load_point(7'd0, 32'h4000_0000, 32'h0100_0000);
    load_point(7'd1, 32'h2000_0000, 32'h0200_0000);
    query(32'h0080_0000);
    query(32'h0100_0000);
    query(32'h0180_0000);
    query(32'h0300_0000);
    query(32'h7FFF_FFFF);
    load_point(7'd1, 32'h2000_0000, 32'h0100_0000);  // equal maturities
    query(32'h0200_0000);
    load_point(7'd1, 32'h7FFF_FFFF, 32'h0000_0000);  // descending
    query(32'h0080_0000);
    load_point(7'd0, 32'h8000_0000, 32'hFFFF_FFFF);
    load_point(7'd127, 32'h1234_5678, 32'h0);
    query(32'h7FFF_FFFF);
    drain();

    while (n_words < 850) begin
      drain();
      write_cfg(CFG_CURVE_MODE, $urandom_range(0, 1));
      write_cfg(CFG_FLAT_RATE, rand_rate());
      count = ($urandom_range(0, 15) == 0) ? 128 : $urandom_range(2, 8);
      write_cfg(CFG_POINT_COUNT, count);
      if (board.mode) begin
        load_table(count);
        repeat ($urandom_range(5, 25)) begin
          if ($urandom_range(0, 9) == 0) begin
            load_point(7'($urandom_range(0, 127)), $urandom, $urandom);
          end else begin
            off = $signed($urandom) >>> $urandom_range(4, 31);
            query(tb_times[$urandom_range(0, count - 1)] + off);
          end
        end
      end else begin
        repeat ($urandom_range(5, 25)) begin
          if ($urandom_range(0, 7) == 0) load_point(7'($urandom), $urandom, $urandom);
          else query(rand_maturity());
        end
      end
    end
    drain();
    repeat (1000) @(posedge clk);

    $display("covered %0d words (%0d queries) over %0d register writes, %0d results checked",
             n_words, n_queries, n_cfg, board.matched);
    if (board.errors == 0 && board.quotes.size() == 0) begin
      $display("discount_curve_price_interpolator_test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.quotes.size());
      $display("discount_curve_price_interpolator_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
